// File: rtl/deq_pkg.sv
`timescale 1ns / 1ps
// Package for the double-ended queue unit.
// Holds the item types, operation and status codes and sizing defaults.
// No dependencies.
package deq_pkg;

    // Default number of slots in the ring buffer.
    localparam int DEPTH_DEF = 16;

    // Widths fixed by the item formats.
    localparam int WORD_W = 64;
    localparam int OCC_W  = 5;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;

    // Operation codes; the two unused codes behave as a peek.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REVERSE    = 3'd4,
        OP_PEEK       = 3'd5
    } t_op;

    // Status codes reported with every result item.
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    // Sequencer states: a successful pop waits in S_FILL for the memory read.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_FILL = 1'b1
    } t_state;

    // One input item.
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [WORD_W-1:0] push_word;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [WORD_W-1:0] front_word;
        logic [WORD_W-1:0] back_word;
        logic [OCC_W-1:0]  occupancy;
        logic              is_empty;
        logic [STAT_W-1:0] status;
    } t_out_item;

endpackage

// File: rtl/double_ended_queue_unit.sv
`timescale 1ns / 1ps
// Top level of the double-ended queue unit: ring pointers, end-word registers,
// sequencer and result register. Depends on deq_pkg and deq_ram.
//
//  channel  | handshake          | payload                     | direction
//  ---------+--------------------+-----------------------------+----------
//  item in  | start, busy        | i_item   (deq_pkg::t_in_item)  | in
//  result   | o_valid (strobe)   | o_result (deq_pkg::t_out_item) | out
//
// An item is taken at an edge with start high and busy low. Pushes, reverse,
// peek and a pop on an empty queue end in the cycle they are taken; a pop that
// succeeds also waits in S_FILL, because the new end word comes from the slot
// memory's registered read port. The result strobe rises the cycle after the
// item's work ends and lasts one cycle; the receiver cannot stall it.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
module double_ended_queue_unit #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  deq_pkg::t_in_item  i_item,
    output logic               o_valid,
    output deq_pkg::t_out_item o_result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 2;

    // Control and pointer registers.
    deq_pkg::t_state    r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic               r_rev, n_rev;
    logic               r_fill_first, n_fill_first;
    logic               r_valid, n_valid;

    // Copies of the physical first and last words.
    logic [deq_pkg::WORD_W-1:0] r_first, n_first;
    logic [deq_pkg::WORD_W-1:0] r_last, n_last;
    deq_pkg::t_out_item         r_result, n_result;
    deq_pkg::t_status           n_status;

    // Memory port signals.
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [AW-1:0]              ram_raddr;
    logic [deq_pkg::WORD_W-1:0] ram_rdata;

    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic [AW-1:0] tail_idx;
    logic [AW-1:0] put_idx;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] put_sum;
    deq_pkg::t_op  op;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] idx);
        return (idx == '0) ? AW'(DEPTH - 1) : idx - AW'(1);
    endfunction

    deq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (deq_pkg::WORD_W),
        .ADDR_W(AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_item.push_word),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign busy     = (r_state != deq_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign op       = deq_pkg::t_op'(i_item.operation);
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // Physical index of the last word and of the slot past it.
    always_comb begin
        tail_sum = SW'(r_head) + SW'(r_count) - SW'(1);
        if (tail_sum >= SW'(DEPTH)) begin
            tail_sum = tail_sum - SW'(DEPTH);
        end
        put_sum = SW'(r_head) + SW'(r_count);
        if (put_sum >= SW'(DEPTH)) begin
            put_sum = put_sum - SW'(DEPTH);
        end
        tail_idx = tail_sum[AW-1:0];
        put_idx  = put_sum[AW-1:0];
    end

    // Next state: a successful pop waits for the read of the new end word.
    always_comb begin
        n_state = r_state;
        case (r_state)
            deq_pkg::S_IDLE: begin
                if (accept && !is_empty &&
                    (op inside {deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK})) begin
                    n_state = deq_pkg::S_FILL;
                end
            end
            deq_pkg::S_FILL: begin
                n_state = deq_pkg::S_IDLE;
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath: pointer updates, memory access and end-word tracking.
    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_rev        = r_rev;
        n_fill_first = r_fill_first;
        n_first      = r_first;
        n_last       = r_last;
        n_status     = deq_pkg::ST_OK;
        n_valid      = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = put_idx;
        ram_raddr    = wrap_inc(r_head);
        case (r_state)
            deq_pkg::S_IDLE: begin
                if (accept) begin
                    case (op)
                        deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
                            if (is_full) begin
                                n_status = deq_pkg::ST_PUSH_FULL;
                            end else if ((op == deq_pkg::OP_PUSH_BACK) != r_rev) begin
                                // Append after the physical last word.
                                ram_we    = 1'b1;
                                ram_waddr = put_idx;
                                n_last    = i_item.push_word;
                                if (is_empty) begin
                                    n_first = i_item.push_word;
                                end
                                n_count = r_count + CW'(1);
                            end else begin
                                // Insert ahead of the physical first word.
                                ram_we    = 1'b1;
                                ram_waddr = wrap_dec(r_head);
                                n_head    = wrap_dec(r_head);
                                n_first   = i_item.push_word;
                                if (is_empty) begin
                                    n_last = i_item.push_word;
                                end
                                n_count = r_count + CW'(1);
                            end
                            n_valid = 1'b1;
                        end
                        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                            if (is_empty) begin
                                n_status = deq_pkg::ST_POP_EMPTY;
                                n_valid  = 1'b1;
                            end else if ((op == deq_pkg::OP_POP_FRONT) != r_rev) begin
                                // Drop the physical first word; fetch its successor.
                                n_head       = wrap_inc(r_head);
                                n_count      = r_count - CW'(1);
                                ram_raddr    = wrap_inc(r_head);
                                n_fill_first = 1'b1;
                            end else begin
                                // Drop the physical last word; fetch its predecessor.
                                n_count      = r_count - CW'(1);
                                ram_raddr    = wrap_dec(tail_idx);
                                n_fill_first = 1'b0;
                            end
                        end
                        deq_pkg::OP_REVERSE: begin
                            n_rev   = !r_rev;
                            n_valid = 1'b1;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            deq_pkg::S_FILL: begin
                // The read issued at acceptance returns the new end word.
                if (r_fill_first) begin
                    n_first = ram_rdata;
                end else begin
                    n_last = ram_rdata;
                end
                n_valid = 1'b1;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // Result item built from the state after the step.
    always_comb begin
        n_result.front_word = '0;
        n_result.back_word  = '0;
        if (n_count != '0) begin
            n_result.front_word = n_rev ? n_last : n_first;
            n_result.back_word  = n_rev ? n_first : n_last;
        end
        n_result.occupancy = deq_pkg::OCC_W'(n_count);
        n_result.is_empty  = (n_count == '0);
        n_result.status    = n_status;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= deq_pkg::S_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_rev        <= 1'b0;
            r_fill_first <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_count      <= n_count;
            r_rev        <= n_rev;
            r_fill_first <= n_fill_first;
            r_valid      <= n_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_last  <= n_last;
        if (n_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // A pop waiting on the memory always ends in a result.
    a_fill_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == deq_pkg::S_FILL) |=> (o_valid && r_state == deq_pkg::S_IDLE))
        else $error("pop fill cycle did not produce a result");

    // The stored count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("stored count exceeds depth");

    // A push that is turned away comes only from a full queue.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == deq_pkg::ST_PUSH_FULL) |-> is_full)
        else $error("push refused while not full");

    // An accepted push on a queue with room grows it by one.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_full &&
         (op == deq_pkg::OP_PUSH_BACK || op == deq_pkg::OP_PUSH_FRONT))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the queue");

endmodule

// File: rtl/deq_ram.sv
`timescale 1ns / 1ps
// Slot memory of the double-ended queue: one write port, one read port,
// registered read data. Uses no package items.
module deq_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
